FILE: hdl/jcs_pkg.sv
package jcs_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_STR        = 3'd1,
        MODE_STR_ESC    = 3'd2,
        MODE_SLASH      = 3'd3,
        MODE_LINE       = 3'd4,
        MODE_BLOCK      = 3'd5,
        MODE_BLOCK_STAR = 3'd6
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } result_t;

    // Results caused by the byte on the input port, plus the current mode.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
        mode_t      mode;
    } lex_t;

endpackage

FILE: hdl/jsonc_comment_stripper.sv
// Channel  Handshake             Beat payload
// -------  --------------------  ---------------------------
// in       in_valid / in_ready   in_byte, in_last
// out      out_valid / out_ready out_byte, has_byte, out_last
//
// One input beat per cycle while in_ready is high; each result is queued.
// A byte that releases a held slash yields two results, and the output side
// pops them one at a time; the result queue (DEPTH entries) absorbs the burst.
// in_ready is high while the queue holds at most DEPTH-2 results.
// Reset clears the lexer mode and empties the queue; no clearing pass.
// An output stall only fills the queue; input stalls leave the state alone.
module jsonc_comment_stripper
#(
    parameter int DEPTH = jcs_pkg::FIFO_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last
);

    localparam int LW = $clog2(DEPTH + 1);

    jcs_pkg::lex_t    lex;
    jcs_pkg::result_t head;
    logic [LW-1:0]    level;
    logic             take;
    logic [1:0]       push_count;

    assign take       = in_valid && in_ready;
    assign push_count = take ? lex.count : 2'd0;

    jcs_lexer u_lexer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (in_byte),
        .in_last (in_last),
        .lex     (lex)
    );

    jcs_result_fifo #(.DEPTH(DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (lex.first),
        .push1      (lex.second),
        .pop        (out_ready),
        .head       (head),
        .level      (level)
    );

    // Keep room for two results so any accepted beat fits.
    assign in_ready  = (level <= LW'(DEPTH - 2));
    assign out_valid = (level != '0);
    assign out_byte  = head.data;
    assign has_byte  = head.has_byte;
    assign out_last  = head.last;

`ifndef NO_ASSERTIONS
    a_mode_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_last |=> lex.mode == jcs_pkg::MODE_NORMAL)
        else $error("lexer mode not back to normal after final beat");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_last |-> lex.count != 2'd0)
        else $error("final beat produced no result");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LW'(DEPTH))
        else $error("result queue overflow");

    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take && !(out_valid && out_ready) |=> $stable(level))
        else $error("queue level moved without a beat");
`endif

endmodule

FILE: hdl/jcs_lexer.sv
module jcs_lexer
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output jcs_pkg::lex_t lex
);

    jcs_pkg::mode_t   mode_reg;
    jcs_pkg::mode_t   mode_next;
    logic [1:0]       count;
    jcs_pkg::result_t r0;
    jcs_pkg::result_t r1;

    always_comb
    begin
        count     = 2'd0;
        r0        = '0;
        r1        = '0;
        mode_next = mode_reg;
        case (mode_reg)
            jcs_pkg::MODE_STR:
            begin
                count = 2'd1;
                r0    = '{data: in_byte, has_byte: 1'b1, last: 1'b0};
                if (in_byte == jcs_pkg::CH_BSLASH)
                    mode_next = jcs_pkg::MODE_STR_ESC;
                else if (in_byte == jcs_pkg::CH_QUOTE)
                    mode_next = jcs_pkg::MODE_NORMAL;
                else
                    mode_next = jcs_pkg::MODE_STR;
            end
            jcs_pkg::MODE_STR_ESC:
            begin
                count     = 2'd1;
                r0        = '{data: in_byte, has_byte: 1'b1, last: 1'b0};
                mode_next = jcs_pkg::MODE_STR;
            end
            jcs_pkg::MODE_SLASH:
            begin
                if (in_byte == jcs_pkg::CH_SLASH && !in_last)
                    mode_next = jcs_pkg::MODE_LINE;
                else if (in_byte == jcs_pkg::CH_SLASH)
                    mode_next = jcs_pkg::MODE_LINE;
                else if (in_byte == jcs_pkg::CH_STAR)
                    mode_next = jcs_pkg::MODE_BLOCK;
                else
                begin
                    // Release the held slash, then treat the byte as plain text.
                    count = 2'd2;
                    r0    = '{data: jcs_pkg::CH_SLASH, has_byte: 1'b1, last: 1'b0};
                    r1    = '{data: in_byte, has_byte: 1'b1, last: 1'b0};
                    if (in_byte == jcs_pkg::CH_QUOTE)
                        mode_next = jcs_pkg::MODE_STR;
                    else
                        mode_next = jcs_pkg::MODE_NORMAL;
                end
            end
            jcs_pkg::MODE_LINE:
            begin
                if (in_byte == jcs_pkg::CH_NL)
                begin
                    count     = 2'd1;
                    r0        = '{data: in_byte, has_byte: 1'b1, last: 1'b0};
                    mode_next = jcs_pkg::MODE_NORMAL;
                end
            end
            jcs_pkg::MODE_BLOCK:
            begin
                if (in_byte == jcs_pkg::CH_STAR)
                    mode_next = jcs_pkg::MODE_BLOCK_STAR;
            end
            jcs_pkg::MODE_BLOCK_STAR:
            begin
                if (in_byte == jcs_pkg::CH_SLASH)
                    mode_next = jcs_pkg::MODE_NORMAL;
                else if (in_byte == jcs_pkg::CH_STAR)
                    mode_next = jcs_pkg::MODE_BLOCK_STAR;
                else
                    mode_next = jcs_pkg::MODE_BLOCK;
            end
            default:
            begin
                if (in_byte == jcs_pkg::CH_SLASH && !in_last)
                    mode_next = jcs_pkg::MODE_SLASH;
                else
                begin
                    count = 2'd1;
                    r0    = '{data: in_byte, has_byte: 1'b1, last: 1'b0};
                    if (in_byte == jcs_pkg::CH_QUOTE)
                        mode_next = jcs_pkg::MODE_STR;
                    else
                        mode_next = jcs_pkg::MODE_NORMAL;
                end
            end
        endcase

        // Mark the final result, or make a bare end marker if nothing came out.
        if (in_last)
        begin
            mode_next = jcs_pkg::MODE_NORMAL;
            if (count == 2'd0)
            begin
                count = 2'd1;
                r0    = '{data: 8'd0, has_byte: 1'b0, last: 1'b1};
            end
            else if (count == 2'd1)
                r0.last = 1'b1;
            else
                r1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= jcs_pkg::MODE_NORMAL;
        else if (take)
            mode_reg <= mode_next;
    end

    assign lex = '{count: count, first: r0, second: r1, mode: mode_reg};

endmodule

FILE: hdl/jcs_result_fifo.sv
module jcs_result_fifo
#(
    parameter int DEPTH = jcs_pkg::FIFO_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   push_count,
    input  jcs_pkg::result_t             push0,
    input  jcs_pkg::result_t             push1,
    input  logic                         pop,
    output jcs_pkg::result_t             head,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    jcs_pkg::result_t mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    wr_ptr_inc;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [LW-1:0]    level_reg;
    logic [LW-1:0]    level_next;
    logic             do_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    assign do_pop     = pop && (level_reg != '0);
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        case (push_count)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + LW'(push_count) - LW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            mem_reg[wr_ptr_inc] <= push1;
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign level = level_reg;

endmodule

FILE: tb/jsonc_comment_stripper_test.sv
`timescale 1ns / 1ps

module jsonc_comment_stripper_test;

    localparam int ITEM_GOAL    = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 5000;
    localparam int PRINT_LIMIT  = 40;

    typedef enum int {
        FRAG_PLAIN,
        FRAG_STRING,
        FRAG_LINE,
        FRAG_BLOCK,
        FRAG_SLASH,
        FRAG_NOISE
    } frag_kind_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_TRICKLE
    } rx_style_t;

    class strip_board;
        jcs_pkg::result_t kept_q[$];
        jcs_pkg::mode_t   lex_mode = jcs_pkg::MODE_NORMAL;
        int               fail_count = 0;
        int               checked_count = 0;

        task report_mismatch(string msg);
            if (fail_count < PRINT_LIMIT)
                $display("MISMATCH at %0t: %s", $realtime, msg);
            fail_count++;
        endtask

        function void queue_result(jcs_pkg::result_t r);
            kept_q.insert(kept_q.size(), r);
        endfunction

        function void keep_char(logic [7:0] c);
            jcs_pkg::result_t r;
            r.data     = c;
            r.has_byte = 1'b1;
            r.last     = 1'b0;
            queue_result(r);
        endfunction

        // Ordinary text: a quote opens a string, a slash is held unless it ends the stream.
        function jcs_pkg::mode_t plain_char(logic [7:0] c, logic l);
            if (c == jcs_pkg::CH_QUOTE)
            begin
                keep_char(c);
                return jcs_pkg::MODE_STR;
            end
            if (c == jcs_pkg::CH_SLASH && !l)
                return jcs_pkg::MODE_SLASH;
            keep_char(c);
            return jcs_pkg::MODE_NORMAL;
        endfunction

        function void note_byte(logic [7:0] c, logic l);
            int               base;
            jcs_pkg::mode_t   nxt;
            jcs_pkg::result_t marker;
            base = kept_q.size();
            case (lex_mode)
                jcs_pkg::MODE_STR:
                begin
                    keep_char(c);
                    if (c == jcs_pkg::CH_BSLASH)
                        nxt = jcs_pkg::MODE_STR_ESC;
                    else if (c == jcs_pkg::CH_QUOTE)
                        nxt = jcs_pkg::MODE_NORMAL;
                    else
                        nxt = jcs_pkg::MODE_STR;
                end
                jcs_pkg::MODE_STR_ESC:
                begin
                    keep_char(c);
                    nxt = jcs_pkg::MODE_STR;
                end
                jcs_pkg::MODE_SLASH:
                begin
                    if (c == jcs_pkg::CH_SLASH)
                        nxt = jcs_pkg::MODE_LINE;
                    else if (c == jcs_pkg::CH_STAR)
                        nxt = jcs_pkg::MODE_BLOCK;
                    else
                    begin
                        keep_char(jcs_pkg::CH_SLASH);
                        nxt = plain_char(c, l);
                    end
                end
                jcs_pkg::MODE_LINE:
                begin
                    if (c == jcs_pkg::CH_NL)
                    begin
                        keep_char(c);
                        nxt = jcs_pkg::MODE_NORMAL;
                    end
                    else
                        nxt = jcs_pkg::MODE_LINE;
                end
                jcs_pkg::MODE_BLOCK:
                    nxt = (c == jcs_pkg::CH_STAR) ? jcs_pkg::MODE_BLOCK_STAR
                                                   : jcs_pkg::MODE_BLOCK;
                jcs_pkg::MODE_BLOCK_STAR:
                begin
                    if (c == jcs_pkg::CH_SLASH)
                        nxt = jcs_pkg::MODE_NORMAL;
                    else if (c == jcs_pkg::CH_STAR)
                        nxt = jcs_pkg::MODE_BLOCK_STAR;
                    else
                        nxt = jcs_pkg::MODE_BLOCK;
                end
                default:
                    nxt = plain_char(c, l);
            endcase
            if (l)
            begin
                // The final byte always closes the stream with exactly one last-flagged beat.
                if (kept_q.size() == base)
                begin
                    marker.data     = 8'h00;
                    marker.has_byte = 1'b0;
                    marker.last     = 1'b1;
                    queue_result(marker);
                end
                else
                    kept_q[kept_q.size() - 1].last = 1'b1;
                nxt = jcs_pkg::MODE_NORMAL;
            end
            lex_mode = nxt;
        endfunction

        task check_result(logic [7:0] c, logic hb, logic l);
            jcs_pkg::result_t want;
            checked_count++;
            if (kept_q.size() == 0)
            begin
                report_mismatch($sformatf("beat %0d with nothing pending: %02h has %b last %b",
                                          checked_count, c, hb, l));
                return;
            end
            want = kept_q.pop_front();
            if (c !== want.data)
                report_mismatch($sformatf("beat %0d out_byte %02h, want %02h",
                                          checked_count, c, want.data));
            if (hb !== want.has_byte)
                report_mismatch($sformatf("beat %0d has_byte %b, want %b",
                                          checked_count, hb, want.has_byte));
            if (l !== want.last)
                report_mismatch($sformatf("beat %0d out_last %b, want %b",
                                          checked_count, l, want.last));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;

    strip_board board;
    logic [7:0] text_q[$];
    int         burst_left = 0;
    int         items_in = 0;
    int         streams_sent = 0;
    int         in_stall_cycles = 0;
    int         idle_cycles = 0;
    bit         random_phase = 1'b0;
    bit         draining = 1'b0;

    jsonc_comment_stripper dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .out_last  (out_last)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                board.note_byte(in_byte, in_last);
                items_in++;
            end
            if (in_valid && !in_ready)
                in_stall_cycles++;
            if (out_valid && out_ready)
                board.check_result(out_byte, has_byte, out_last);
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(5, 30);
            else
                gap = $urandom_range(0, 2);
            burst_left = $urandom_range(1, 30);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= c;
        in_last  <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
        streams_sent++;
    endtask

    function automatic void queue_char(logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            4:       return jcs_pkg::CH_SLASH;
            5:       return jcs_pkg::CH_STAR;
            6:       return jcs_pkg::CH_QUOTE;
            7:       return jcs_pkg::CH_BSLASH;
            8:       return jcs_pkg::CH_NL;
            9:       return 8'h61 + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed fragments with random content; noise breaks them up.
    function automatic void add_fragment();
        frag_kind_t kind;
        int         k;
        int         i;
        kind = frag_kind_t'($urandom_range(0, 5));
        k    = $urandom_range(0, 6);
        case (kind)
            FRAG_STRING:
            begin
                queue_char(jcs_pkg::CH_QUOTE);
                for (i = 0; i < k; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        queue_char(jcs_pkg::CH_BSLASH);
                        queue_char($urandom_range(0, 1) ? jcs_pkg::CH_QUOTE : pick_char());
                    end
                    else
                        queue_char(pick_char());
                end
                if ($urandom_range(0, 7) != 0)
                    queue_char(jcs_pkg::CH_QUOTE);
            end
            FRAG_LINE:
            begin
                queue_char(jcs_pkg::CH_SLASH);
                queue_char(jcs_pkg::CH_SLASH);
                for (i = 0; i < k; i++)
                    queue_char(pick_char());
                if ($urandom_range(0, 5) != 0)
                    queue_char(jcs_pkg::CH_NL);
            end
            FRAG_BLOCK:
            begin
                queue_char(jcs_pkg::CH_SLASH);
                queue_char(jcs_pkg::CH_STAR);
                for (i = 0; i < k; i++)
                    queue_char(pick_char());
                if ($urandom_range(0, 5) != 0)
                begin
                    repeat ($urandom_range(1, 3))
                        queue_char(jcs_pkg::CH_STAR);
                    queue_char(jcs_pkg::CH_SLASH);
                end
            end
            FRAG_SLASH:
            begin
                queue_char(jcs_pkg::CH_SLASH);
                queue_char(pick_char());
            end
            FRAG_PLAIN:
            begin
                for (i = 0; i <= k; i++)
                    queue_char(8'h20 + 8'($urandom_range(0, 94)));
            end
            default:
            begin
                for (i = 0; i <= k % 4; i++)
                    queue_char(pick_char());
            end
        endcase
    endfunction

    task automatic send_random_stream();
        int i;
        text_q.delete();
        repeat ($urandom_range(1, 5))
            add_fragment();
        for (i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        streams_sent++;
    endtask

    // Receiver: stall patterns in phases, with one long hold-off once random traffic starts.
    initial
    begin
        int        phase_len;
        int        k;
        bit        hold_done;
        rx_style_t style;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (random_phase && !hold_done)
            begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
            end
            phase_len = $urandom_range(10, 120);
            style     = rx_style_t'($urandom_range(0, 3));
            for (k = 0; k < phase_len; k++)
            begin
                @(negedge clk);
                if (draining)
                    out_ready <= 1'b1;
                else
                    case (style)
                        RX_OPEN:         out_ready <= 1'b1;
                        RX_COIN:         out_ready <= 1'($urandom_range(0, 1));
                        RX_EVERY_FOURTH: out_ready <= (k % 4) != 3;
                        default:         out_ready <= ($urandom_range(0, 7) == 0);
                    endcase
            end
        end
    end

    initial
    begin
        board    = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h00;
        in_last  = 1'b0;
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        // Byte extremes pass straight through normal text.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        streams_sent++;
        send_text("/");
        send_text("/\"\\");
        send_text("//\n");
        send_text("/*/*/");
        send_text("/*a");
        send_text("a//");

        random_phase = 1'b1;
        while (items_in < ITEM_GOAL)
            send_random_stream();

        @(negedge clk);
        in_valid <= 1'b0;
        draining = 1'b1;
        while (board.kept_q.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);

        $display("Checked %0d result beats from %0d input bytes in %0d streams",
                 board.checked_count, items_in, streams_sent);
        $display("Input was back-pressured for %0d cycles; %0d mismatches",
                 in_stall_cycles, board.fail_count);
        if (board.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: jsonc_comment_stripper.f
hdl/jcs_pkg.sv
hdl/jcs_lexer.sv
hdl/jcs_result_fifo.sv
hdl/jsonc_comment_stripper.sv
tb/jsonc_comment_stripper_test.sv
